/* rtl/core/integer_key_set_table_macros.svh */
// Assertion macros for the key set table.
`ifndef INTEGER_KEY_SET_TABLE_MACROS_SVH
`define INTEGER_KEY_SET_TABLE_MACROS_SVH

// Same-cycle implication, checked on clk, off during reset.
`define IKS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on clk, off during reset.
`define IKS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/iks_pkg.sv */
// Types and codes shared by the key set table files.
package iks_pkg;

    localparam int KEY_W    = 32;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;

    localparam logic [STATUS_W-1:0] STAT_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_DUPLICATE = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd3;

    // One table slot: valid mark and key.
    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
    } slot_t;

endpackage

/* rtl/core/iks_cmd_if.sv */
// Command channel: one word is an operation code and a key.
interface iks_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [iks_pkg::CMD_W-1:0]           command;
    logic signed [iks_pkg::KEY_W-1:0]    key;

    modport source (output valid, output command, output key, input ready);
    modport sink   (input valid, input command, input key, output ready);
endinterface

/* rtl/core/iks_rsp_if.sv */
// Response channel: one word per command.
interface iks_rsp_if;
    logic                                valid;
    logic                                ready;
    logic                                was_present;
    logic [iks_pkg::STATUS_W-1:0]        status;
    logic [iks_pkg::COUNT_W-1:0]         entry_count;

    modport source (output valid, output was_present, output status, output entry_count,
                    input ready);
    modport sink   (input valid, input was_present, input status, input entry_count,
                    output ready);
endinterface

/* rtl/core/integer_key_set_table.sv */
// Key set table: insert, remove or query one key against CAPACITY slots, one word per command.
// From command accept the sequencer runs slot scan, drain and apply; apply waits for the output register.
// Commands are handled one at a time; the scan reads the slots through the single read port of the slot memory.
// A new command is taken while the previous response still waits in the output register.
// Reset (rst_n, async, active low) starts a clearing pass over all CAPACITY slots of the slot
// memory; no command is taken until it ends. Count and response valid reset to zero.
`include "integer_key_set_table_macros.svh"

module integer_key_set_table #(
    parameter int CAPACITY = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    iks_cmd_if.sink   req,
    iks_rsp_if.source rsp
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

    // Sequencer codes.
    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_APPLY = 3'd4;

    logic [2:0] state_reg, state_next;

    // Slot memory: one write port, one registered read port.
    iks_pkg::slot_t mem [CAPACITY];
    iks_pkg::slot_t rd_data_reg;
    iks_pkg::slot_t mem_wdata;
    logic           mem_we;
    logic [IDX_W-1:0] mem_waddr;

    // Scan address (also the clearing pass address).
    logic [IDX_W-1:0] scan_idx_reg, scan_idx_next;

    // Read pipeline tag: which slot rd_data_reg holds.
    logic             pipe_vld_reg;
    logic [IDX_W-1:0] pipe_idx_reg;

    // Command held during the scan.
    logic [iks_pkg::CMD_W-1:0]        cmd_reg;
    logic signed [iks_pkg::KEY_W-1:0] key_reg;

    // Scan results.
    logic             hit_reg, hit_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic             free_reg, free_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;

    logic [CNT_W-1:0] held_count_reg, held_count_next;

    // Response register.
    logic                            rsp_valid_reg, rsp_valid_next;
    logic                            rsp_present_reg, rsp_present_next;
    logic [iks_pkg::STATUS_W-1:0]    rsp_status_reg, rsp_status_next;
    logic [iks_pkg::COUNT_W-1:0]     rsp_count_reg, rsp_count_next;

    logic accept;
    logic apply_go;
    logic slot_hit;
    logic slot_free;

    assign req.ready       = (state_reg == ST_IDLE);
    assign accept          = req.valid && req.ready;
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.was_present = rsp_present_reg;
    assign rsp.status      = rsp_status_reg;
    assign rsp.entry_count = rsp_count_reg;

    // Apply only once the output register is free or being emptied.
    assign apply_go = (state_reg == ST_APPLY) && (!rsp_valid_reg || rsp.ready);

    // Shared comparator on the slot coming out of memory.
    assign slot_hit  = pipe_vld_reg && rd_data_reg.valid && (rd_data_reg.key == key_reg);
    assign slot_free = pipe_vld_reg && !rd_data_reg.valid;

    always_comb
    begin
        state_next       = state_reg;
        scan_idx_next    = scan_idx_reg;
        hit_next         = hit_reg;
        hit_idx_next     = hit_idx_reg;
        free_next        = free_reg;
        free_idx_next    = free_idx_reg;
        held_count_next  = held_count_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp.ready;
        rsp_present_next = rsp_present_reg;
        rsp_status_next  = rsp_status_reg;
        rsp_count_next   = rsp_count_reg;
        mem_we           = 1'b0;
        mem_waddr        = scan_idx_reg;
        mem_wdata        = '{valid: 1'b0, key: key_reg};

        if (slot_hit)
        begin
            hit_next     = 1'b1;
            hit_idx_next = pipe_idx_reg;
        end
        if (slot_free && !free_reg)
        begin
            free_next     = 1'b1;
            free_idx_next = pipe_idx_reg;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we = 1'b1;
                if (scan_idx_reg == LAST_IDX)
                begin
                    scan_idx_next = '0;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    hit_next      = 1'b0;
                    free_next     = 1'b0;
                    scan_idx_next = '0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_idx_reg == LAST_IDX)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                if (apply_go)
                begin
                    rsp_valid_next   = 1'b1;
                    rsp_present_next = hit_reg;
                    rsp_status_next  = iks_pkg::STAT_DONE;
                    if (cmd_reg == iks_pkg::CMD_INSERT)
                    begin
                        if (hit_reg)
                        begin
                            rsp_status_next = iks_pkg::STAT_DUPLICATE;
                        end
                        else if (!free_reg)
                        begin
                            rsp_status_next = iks_pkg::STAT_FULL;
                        end
                        else
                        begin
                            mem_we          = 1'b1;
                            mem_waddr       = free_idx_reg;
                            mem_wdata.valid = 1'b1;
                            held_count_next = held_count_reg + 1'b1;
                        end
                    end
                    else if (cmd_reg == iks_pkg::CMD_REMOVE)
                    begin
                        if (hit_reg)
                        begin
                            mem_we          = 1'b1;
                            mem_waddr       = hit_idx_reg;
                            held_count_next = held_count_reg - 1'b1;
                        end
                        else
                        begin
                            rsp_status_next = iks_pkg::STAT_NOT_FOUND;
                        end
                    end
                    rsp_count_next = iks_pkg::COUNT_W'(held_count_next);
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            scan_idx_reg   <= '0;
            pipe_vld_reg   <= 1'b0;
            hit_reg        <= 1'b0;
            free_reg       <= 1'b0;
            held_count_reg <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_idx_reg   <= scan_idx_next;
            pipe_vld_reg   <= (state_reg == ST_SCAN);
            hit_reg        <= hit_next;
            free_reg       <= free_next;
            held_count_reg <= held_count_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        pipe_idx_reg    <= scan_idx_reg;
        hit_idx_reg     <= hit_idx_next;
        free_idx_reg    <= free_idx_next;
        rsp_present_reg <= rsp_present_next;
        rsp_status_reg  <= rsp_status_next;
        rsp_count_reg   <= rsp_count_next;
        if (accept)
        begin
            cmd_reg <= req.command;
            key_reg <= req.key;
        end
    end

    // Slot memory.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[scan_idx_reg];
    end

    `IKS_ASSERT_NOW(a_count_bound, 1'b1, held_count_reg <= CNT_W'(CAPACITY), "count above capacity")
    `IKS_ASSERT_NOW(a_dup_present, rsp_valid_reg && rsp_status_reg == iks_pkg::STAT_DUPLICATE, rsp_present_reg, "duplicate without hit")
    `IKS_ASSERT_NOW(a_miss_absent, rsp_valid_reg && (rsp_status_reg == iks_pkg::STAT_NOT_FOUND || rsp_status_reg == iks_pkg::STAT_FULL), !rsp_present_reg, "miss status with hit")
    `IKS_ASSERT_NEXT(a_drain_apply, state_reg == ST_DRAIN, state_reg == ST_APPLY, "drain not followed by apply")

endmodule

/* tb/sv/integer_key_set_table_tb.sv */
// Self-checking testbench for the key set table: directed and random insert/remove/query traffic.
`timescale 1ns / 1ps

module integer_key_set_table_tb;

    localparam int TABLE_SLOTS  = 16;
    localparam int TARGET_WORDS = 1900;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int LONG_HOLD    = 250;
    localparam int POOL_SIZE    = 20;

    // Query codes are not in the package. Code three decodes as a query too.
    localparam logic [iks_pkg::CMD_W-1:0] CMD_QUERY = 2'd2;
    localparam logic [iks_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;

    typedef struct packed {
        logic [iks_pkg::CMD_W-1:0] command;
        logic [iks_pkg::KEY_W-1:0] key;
    } cmd_word_t;

    typedef struct packed {
        logic                         was_present;
        logic [iks_pkg::STATUS_W-1:0] status;
        logic [iks_pkg::COUNT_W-1:0]  entry_count;
    } table_reply_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Block inputs live in initialized variables so they are known from time zero.
    logic                      cmd_valid = 1'b0;
    logic [iks_pkg::CMD_W-1:0] cmd_code  = '0;
    logic [iks_pkg::KEY_W-1:0] cmd_key   = '0;
    logic                      rsp_ready = 1'b0;

    iks_cmd_if cmd_ch ();
    iks_rsp_if rsp_ch ();

    assign cmd_ch.valid   = cmd_valid;
    assign cmd_ch.command = cmd_code;
    assign cmd_ch.key     = cmd_key;
    assign rsp_ch.ready   = rsp_ready;

    integer_key_set_table #(
        .CAPACITY (TABLE_SLOTS)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cmd_ch),
        .rsp   (rsp_ch)
    );

    always #6 clk = ~clk;

    // Words waiting to be offered, and replies predicted but not yet seen.
    cmd_word_t    pending_q[$];
    table_reply_t reply_q[$];

    // Shadow copy of the table.
    logic [iks_pkg::KEY_W-1:0] shadow_keys [TABLE_SLOTS];
    logic                      shadow_used [TABLE_SLOTS];
    int                        shadow_count = 0;

    int  error_count    = 0;
    int  queued_words   = 0;
    int  accepted_words = 0;
    int  send_gap       = 0;
    int  recv_gap       = 0;
    int  cycle_count    = 0;
    bit  idle_on        = 1'b1;
    bit  rsp_hold       = 1'b0;

    logic [iks_pkg::KEY_W-1:0] key_pool [POOL_SIZE];

    initial
    begin
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            shadow_keys[i] = '0;
            shadow_used[i] = 1'b0;
        end
    end

    // Mostly back-to-back, sometimes a few cycles, rarely a long pause.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 4);
        else
            return $urandom_range(10, 40);
    endfunction

    // Apply one command to the shadow table and return the reply it should give.
    // Lookup is over valid slots only; insert takes the lowest free slot.
    function automatic table_reply_t predict_reply(logic [iks_pkg::CMD_W-1:0] op,
                                                   logic [iks_pkg::KEY_W-1:0] k);
        table_reply_t r;
        int           hit;
        int           free_slot;
        hit       = -1;
        free_slot = -1;
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            if (hit < 0 && shadow_used[i] && shadow_keys[i] == k)
                hit = i;
            if (free_slot < 0 && !shadow_used[i])
                free_slot = i;
        end
        r.was_present = (hit >= 0);
        r.status      = iks_pkg::STAT_DONE;
        if (op == iks_pkg::CMD_INSERT)
        begin
            if (hit >= 0)
                r.status = iks_pkg::STAT_DUPLICATE;
            else if (free_slot < 0)
                r.status = iks_pkg::STAT_FULL;
            else
            begin
                shadow_keys[free_slot] = k;
                shadow_used[free_slot] = 1'b1;
                shadow_count++;
            end
        end
        else if (op == iks_pkg::CMD_REMOVE)
        begin
            if (hit >= 0)
            begin
                shadow_used[hit] = 1'b0;
                shadow_count--;
            end
            else
                r.status = iks_pkg::STAT_NOT_FOUND;
        end
        r.entry_count = iks_pkg::COUNT_W'(shadow_count);
        return r;
    endfunction

    // Command driver: predicts at acceptance, then offers the next queued word after a gap.
    always @(posedge clk)
    begin : cmd_driver
        cmd_word_t nxt;
        bit        slot_open;
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            send_gap  = 0;
        end
        else
        begin
            slot_open = !cmd_valid;
            if (cmd_valid && cmd_ch.ready)
            begin
                reply_q.push_back(predict_reply(cmd_code, cmd_key));
                accepted_words++;
                slot_open = 1'b1;
            end
            if (slot_open)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    cmd_valid <= 1'b0;
                end
                else if (pending_q.size() > 0)
                begin
                    nxt = pending_q.pop_front();
                    cmd_code  <= nxt.command;
                    cmd_key   <= nxt.key;
                    cmd_valid <= 1'b1;
                    send_gap  = idle_on ? idle_len() : 0;
                end
                else
                    cmd_valid <= 1'b0;
            end
        end
    end

    // Response monitor: checks every accepted word against the oldest prediction.
    always @(posedge clk)
    begin : rsp_monitor
        table_reply_t want;
        table_reply_t got;
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            recv_gap  = 0;
        end
        else
        begin
            if (rsp_ready && rsp_ch.valid)
            begin
                got.was_present = rsp_ch.was_present;
                got.status      = rsp_ch.status;
                got.entry_count = rsp_ch.entry_count;
                if (reply_q.size() == 0)
                begin
                    $display("%0t: unexpected response: present=%0b status=%0d count=%0d",
                             $time, got.was_present, got.status, got.entry_count);
                    error_count++;
                end
                else
                begin
                    want = reply_q.pop_front();
                    if (got !== want)
                    begin
                        $display({"%0t: mismatch: expected present=%0b status=%0d count=%0d,",
                                  " actual present=%0b status=%0d count=%0d"},
                                 $time, want.was_present, want.status, want.entry_count,
                                 got.was_present, got.status, got.entry_count);
                        error_count++;
                    end
                end
            end
            if (rsp_hold)
                rsp_ready <= 1'b0;
            else if (recv_gap > 0)
            begin
                recv_gap--;
                rsp_ready <= 1'b0;
            end
            else
            begin
                rsp_ready <= 1'b1;
                if (idle_on && $urandom_range(0, 3) == 0)
                    recv_gap = idle_len();
            end
        end
    end

    // Long receiver hold-off once traffic is flowing: the output register fills, one more
    // command is taken, then the block must drop ready on the command side.
    initial
    begin : rsp_long_hold
        while (accepted_words < 300 || pending_q.size() < 10)
            @(negedge clk);
        rsp_hold = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        rsp_hold = 1'b0;
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic queue_word(logic [iks_pkg::CMD_W-1:0] op, logic [iks_pkg::KEY_W-1:0] k);
        cmd_word_t w;
        w.command = op;
        w.key     = k;
        pending_q.push_back(w);
        queued_words++;
    endtask

    // Sender pause: hold off until every predicted reply has been checked.
    task automatic wait_drained();
        while (pending_q.size() != 0 || cmd_valid || reply_q.size() != 0)
            @(negedge clk);
    endtask

    // Key pool: the four extremes, a few small values, the rest full-width random.
    // Pool is larger than the table so fill sequences run into the full case.
    task automatic build_pool();
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7fff_ffff;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hffff_ffff;
        for (int i = 4; i < POOL_SIZE; i++)
        begin
            if (i < 10)
                key_pool[i] = iks_pkg::KEY_W'($urandom_range(0, 15)) - 32'd8;
            else
                key_pool[i] = $urandom();
        end
    endtask

    function automatic logic [iks_pkg::CMD_W-1:0] random_op();
        int r;
        r = $urandom_range(0, 19);
        if (r < 8)
            return iks_pkg::CMD_INSERT;
        else if (r < 14)
            return iks_pkg::CMD_REMOVE;
        else if (r < 19)
            return CMD_QUERY;
        else
            return CMD_SPARE;
    endfunction

    task automatic mixed_phase(int n);
        logic [iks_pkg::KEY_W-1:0] k;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                k = $urandom();
            else
                k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            queue_word(random_op(), k);
        end
    endtask

    // Insert the whole pool, churn a while, then remove the whole pool, each in shuffled order.
    task automatic fill_and_drain_phase();
        int order [POOL_SIZE];
        int j;
        int t;
        for (int i = 0; i < POOL_SIZE; i++)
            order[i] = i;
        for (int i = POOL_SIZE - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        for (int i = 0; i < POOL_SIZE; i++)
            queue_word(iks_pkg::CMD_INSERT, key_pool[order[i]]);
        mixed_phase(30);
        for (int i = POOL_SIZE - 1; i >= 0; i--)
            queue_word(iks_pkg::CMD_REMOVE, key_pool[order[i]]);
    endtask

    // Noise: any code, any key.
    task automatic noise_phase(int n);
        for (int i = 0; i < n; i++)
            queue_word(iks_pkg::CMD_W'($urandom_range(0, 3)), $urandom());
    endtask

    initial
    begin : stimulus
        int phase;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: extremes, every code, duplicate, absent remove, full table.
        queue_word(iks_pkg::CMD_INSERT, 32'h8000_0000);
        queue_word(iks_pkg::CMD_INSERT, 32'h7fff_ffff);
        queue_word(iks_pkg::CMD_INSERT, 32'h0000_0000);
        queue_word(iks_pkg::CMD_INSERT, 32'hffff_ffff);
        queue_word(iks_pkg::CMD_INSERT, 32'h8000_0000);   // duplicate
        queue_word(CMD_QUERY,           32'h7fff_ffff);
        queue_word(CMD_SPARE,           32'h0000_0000);   // code three answers as a query
        queue_word(CMD_QUERY,           32'h1234_5678);   // absent
        queue_word(iks_pkg::CMD_REMOVE, 32'h5555_aaaa);   // not found
        queue_word(iks_pkg::CMD_REMOVE, 32'h8000_0000);
        queue_word(iks_pkg::CMD_REMOVE, 32'h8000_0000);   // already gone
        for (int i = 0; i < 13; i++)
            queue_word(iks_pkg::CMD_INSERT, 32'h1 << i);  // table now full
        queue_word(iks_pkg::CMD_INSERT, 32'h5555_aaaa);   // refused, full
        queue_word(iks_pkg::CMD_INSERT, 32'h0000_0000);   // held key on a full table
        queue_word(CMD_SPARE,           32'h0000_1000);
        queue_word(iks_pkg::CMD_REMOVE, 32'hffff_ffff);
        wait_drained();

        phase = 0;
        while (queued_words < TARGET_WORDS)
        begin
            if (phase % 3 == 0)
                build_pool();
            idle_on = (phase % 5 != 2);
            case (phase % 3)
                0: fill_and_drain_phase();
                1: mixed_phase(90);
                default:
                begin
                    noise_phase(30);
                    mixed_phase(40);
                end
            endcase
            if (phase % 4 == 3)
                wait_drained();
            phase++;
        end

        wait_drained();
        repeat (4 * TABLE_SLOTS) @(negedge clk);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/iks_pkg.sv
rtl/core/iks_cmd_if.sv
rtl/core/iks_rsp_if.sv
rtl/core/integer_key_set_table.sv
tb/sv/integer_key_set_table_tb.sv
